@@ rtl/core/gtg_pkg.sv @@
`timescale 1ns / 1ps
package gtg_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int CordicSteps = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
    localparam int SqrtDigits = 17;
    localparam int NumSteps = (CordicSteps > SqrtDigits) ? CordicSteps : SqrtDigits;
    localparam int Latency = NumSteps + 6;

    localparam int XyW = 28;
    localparam int ZW = 24;
    localparam logic signed [ZW-1:0] HalfPi = 24'sd1647099;

    localparam logic [2:0] REG_GOAL_X = 3'd0;
    localparam logic [2:0] REG_GOAL_Y = 3'd1;
    localparam logic [2:0] REG_TOLERANCE = 3'd2;
    localparam logic [2:0] REG_LINEAR_GAIN = 3'd3;
    localparam logic [2:0] REG_ANGULAR_GAIN = 3'd4;

    typedef struct packed {
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic signed [15:0] pose_heading;
    } t_pose;

    typedef struct packed {
        logic [15:0] linear_cmd;
        logic signed [15:0] angular_cmd;
        logic reached;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic reached;
        logic signed [15:0] heading;
        logic [33:0] sq;
        logic [19:0] rem;
        logic [16:0] root;
        logic signed [XyW-1:0] x;
        logic signed [XyW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_stage;

    function automatic logic signed [ZW-1:0] atan_angle(input logic [4:0] idx);
        logic signed [ZW-1:0] a;
        case (idx)
            5'd0: a = 24'sd823550;
            5'd1: a = 24'sd486170;
            5'd2: a = 24'sd256879;
            5'd3: a = 24'sd130396;
            5'd4: a = 24'sd65451;
            5'd5: a = 24'sd32757;
            5'd6: a = 24'sd16383;
            5'd7: a = 24'sd8192;
            5'd8: a = 24'sd4096;
            5'd9: a = 24'sd2048;
            5'd10: a = 24'sd1024;
            5'd11: a = 24'sd512;
            5'd12: a = 24'sd256;
            5'd13: a = 24'sd128;
            5'd14: a = 24'sd64;
            5'd15: a = 24'sd32;
            5'd16: a = 24'sd16;
            5'd17: a = 24'sd8;
            5'd18: a = 24'sd4;
            5'd19: a = 24'sd2;
            5'd20: a = 24'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/core/gtg_step.sv @@
`timescale 1ns / 1ps
module gtg_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_stage,
    input  gtg_pkg::t_stage    i_d,
    output gtg_pkg::t_stage    o_q
);

    gtg_pkg::t_stage r_q;
    gtg_pkg::t_stage n_q;
    logic [19:0] rem_sh;
    logic [19:0] trial;
    logic signed [gtg_pkg::XyW-1:0] xs;
    logic signed [gtg_pkg::XyW-1:0] ys;

    always_comb begin
        n_q = i_d;
        n_q.valid = i_d.valid && i_rst_n;
        rem_sh = {i_d.rem[17:0], i_d.sq[33:32]};
        trial = {1'b0, i_d.root, 2'b01};
        xs = i_d.x >>> i_stage;
        ys = i_d.y >>> i_stage;
        if (32'(i_stage) < gtg_pkg::SqrtDigits) begin
            n_q.sq = {i_d.sq[31:0], 2'b00};
            if (rem_sh >= trial) begin
                n_q.rem = rem_sh - trial;
                n_q.root = {i_d.root[15:0], 1'b1};
            end else begin
                n_q.rem = rem_sh;
                n_q.root = {i_d.root[15:0], 1'b0};
            end
        end
        if (32'(i_stage) < gtg_pkg::CordicSteps) begin
            if (!i_d.y[gtg_pkg::XyW-1]) begin
                n_q.x = i_d.x + ys;
                n_q.y = i_d.y - xs;
                n_q.z = i_d.z + gtg_pkg::atan_angle(i_stage);
            end else begin
                n_q.x = i_d.x - ys;
                n_q.y = i_d.y + xs;
                n_q.z = i_d.z - gtg_pkg::atan_angle(i_stage);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

@@ rtl/core/go_to_goal_proportional_controller_unit.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                Transfer
// pose      i_start, o_busy, i_pose              i_start high while o_busy is low
// command   o_valid, o_result                    o_valid high for one cycle
// config    i_cfg_we, i_cfg_addr, i_cfg_wdata    i_cfg_we high
//
// One pose enters every cycle. The length of the step chain, and so of the pipeline,
// is set by the seventeen square root digit stages, which outnumber the sixteen CORDIC
// iterations that run beside them.
// Reset is synchronous and clears every stage valid bit; o_busy is high only
// during reset. The receiver cannot stall, so the pipeline never holds.
module go_to_goal_proportional_controller_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  gtg_pkg::t_pose i_pose,
    output logic           o_valid,
    output gtg_pkg::t_cmd  o_result,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_addr,
    input  logic [15:0]    i_cfg_wdata
);

    logic signed [15:0] r_goal_x;
    logic signed [15:0] r_goal_y;
    logic [15:0] r_tol;
    logic [11:0] r_lgain;
    logic [11:0] r_again;

    logic r_v1;
    logic signed [16:0] r_dx;
    logic signed [16:0] r_dy;
    logic signed [15:0] r_hd1;

    logic r_v2;
    logic [33:0] r_dx2;
    logic [33:0] r_dy2;
    logic [31:0] r_tol2;
    logic signed [16:0] r_dx2s;
    logic signed [16:0] r_dy2s;
    logic signed [15:0] r_hd2;

    gtg_pkg::t_stage n_s0;
    gtg_pkg::t_stage r_s0;
    gtg_pkg::t_stage w_st [gtg_pkg::NumSteps+1];

    logic r_v4;
    logic r_re4;
    logic [16:0] r_dist4;
    logic signed [17:0] r_err;

    logic r_v5;
    logic r_re5;
    logic [28:0] r_plin;
    logic signed [30:0] r_pang;

    logic r_v6;
    gtg_pkg::t_cmd r_out;

    logic [33:0] sum_s;
    logic signed [gtg_pkg::XyW-1:0] ex;
    logic signed [gtg_pkg::XyW-1:0] ey;
    logic signed [gtg_pkg::ZW-1:0] zr;
    logic signed [16:0] bearing;
    logic [28:0] lin_r;
    logic signed [30:0] ang_r;
    gtg_pkg::t_cmd n_out;

    assign o_busy = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_tol <= 16'd20;
            r_lgain <= 12'd384;
            r_again <= 12'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gtg_pkg::REG_GOAL_X: r_goal_x <= i_cfg_wdata;
                gtg_pkg::REG_GOAL_Y: r_goal_y <= i_cfg_wdata;
                gtg_pkg::REG_TOLERANCE: r_tol <= i_cfg_wdata;
                gtg_pkg::REG_LINEAR_GAIN: r_lgain <= i_cfg_wdata[11:0];
                gtg_pkg::REG_ANGULAR_GAIN: r_again <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sum_s = r_dx2 + r_dy2;
        n_s0 = '0;
        n_s0.valid = r_v2 && i_rst_n;
        n_s0.reached = (sum_s <= {2'b00, r_tol2});
        n_s0.heading = r_hd2;
        n_s0.sq = sum_s;
        if (r_dx2s < 0) begin
            if (r_dy2s >= 0) begin
                ex = gtg_pkg::XyW'(r_dy2s);
                ey = -gtg_pkg::XyW'(r_dx2s);
                n_s0.z = gtg_pkg::HalfPi;
            end else begin
                ex = -gtg_pkg::XyW'(r_dy2s);
                ey = gtg_pkg::XyW'(r_dx2s);
                n_s0.z = -gtg_pkg::HalfPi;
            end
        end else begin
            ex = gtg_pkg::XyW'(r_dx2s);
            ey = gtg_pkg::XyW'(r_dy2s);
        end
        n_s0.x = ex <<< 8;
        n_s0.y = ey <<< 8;
    end

    always_ff @(posedge i_clk) begin
        r_dx <= 17'(r_goal_x) - 17'(i_pose.pose_x);
        r_dy <= 17'(r_goal_y) - 17'(i_pose.pose_y);
        r_hd1 <= i_pose.pose_heading;
        r_dx2 <= 34'(r_dx) * 34'(r_dx);
        r_dy2 <= 34'(r_dy) * 34'(r_dy);
        r_tol2 <= r_tol * r_tol;
        r_dx2s <= r_dx;
        r_dy2s <= r_dy;
        r_hd2 <= r_hd1;
        r_s0 <= n_s0;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    assign w_st[0] = r_s0;

    for (genvar g = 0; g < gtg_pkg::NumSteps; g++) begin : g_step
        gtg_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (5'(g)),
            .i_d     (w_st[g]),
            .o_q     (w_st[g+1])
        );
    end

    always_comb begin
        zr = w_st[gtg_pkg::NumSteps].z + gtg_pkg::ZW'(64);
        bearing = zr[gtg_pkg::ZW-1:7];
        lin_r = r_plin + 29'd1024;
        ang_r = r_pang + 31'sd1024;
        n_out = '0;
        n_out.reached = r_re5;
        if (!r_re5) begin
            if (lin_r[28:11] > 18'd65535) begin
                n_out.linear_cmd = 16'hFFFF;
            end else begin
                n_out.linear_cmd = lin_r[26:11];
            end
            if ($signed(ang_r[30:11]) > 20'sd32767) begin
                n_out.angular_cmd = 16'sh7FFF;
            end else if ($signed(ang_r[30:11]) < -20'sd32768) begin
                n_out.angular_cmd = 16'sh8000;
            end else begin
                n_out.angular_cmd = ang_r[26:11];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_re4 <= w_st[gtg_pkg::NumSteps].reached;
        r_dist4 <= w_st[gtg_pkg::NumSteps].root;
        r_err <= 18'(bearing) - 18'(w_st[gtg_pkg::NumSteps].heading);
        r_re5 <= r_re4;
        r_plin <= r_lgain * r_dist4;
        r_pang <= 31'($signed({1'b0, r_again})) * 31'(r_err);
        r_out <= n_out;
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v4 <= w_st[gtg_pkg::NumSteps].valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    assign o_valid = r_v6;
    assign o_result = r_out;

endmodule

@@ rtl/core/gtg_checker.sv @@
`timescale 1ns / 1ps
module gtg_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_busy,
    input logic          o_valid,
    input gtg_pkg::t_cmd o_result
);

    a_reached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.reached) |->
        (o_result.linear_cmd == 16'd0 && o_result.angular_cmd == 16'sd0))
        else $error("reached command carries non-zero speeds");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("command strobe after reset");

    a_busy_reset: assert property (@(posedge i_clk)
        i_rst_n |-> !o_busy)
        else $error("busy outside reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n, 1) |-> !o_valid)
        else $error("command right after reset");

endmodule

bind go_to_goal_proportional_controller_unit gtg_checker u_gtg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
